[rtl/assert_macros.svh]
// Assertion macros shared by the trim reference generator RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CTRG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ctrg assertion failed");
`define CTRG_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ctrg forbidden condition seen");
`endif

[rtl/ctrg_pkg.sv]
// Package of the trim reference generator: widths, codes, constants and
// the types between the sequencer and the shared divide/root unit. No dependencies.
package ctrg_pkg;

    localparam int TIME_WIDTH     = 48;
    localparam int REF_WIDTH      = 32;
    localparam int DUR_WIDTH      = 32;
    localparam int CFG_DATA_WIDTH = 48;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int NUM_WIDTH      = 76;
    localparam int DEN_WIDTH      = 33;
    localparam int REM_WIDTH      = 34;
    localparam int MUL_A_WIDTH    = 35;
    localparam int MUL_B_WIDTH    = 32;
    localparam int PROD_WIDTH     = MUL_A_WIDTH + MUL_B_WIDTH;
    localparam int CNT_WIDTH      = 7;
    localparam int DIV_STEPS      = 76;
    localparam int SQRT_STEPS     = 32;
    localparam int ACC_SPLIT      = 21;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_INITIAL = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FINAL   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KIND    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DUR     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RATE    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ACCEL   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DELAY   = 3'd6;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_TYPE  = 3'd1;
    localparam logic [2:0] STS_NO_LIMITS = 3'd2;
    localparam logic [2:0] STS_BAD_ACCEL = 3'd3;
    localparam logic [2:0] STS_NOT_PREP  = 3'd4;

    localparam logic [1:0] KIND_LINEAR = 2'd0;
    localparam logic [1:0] KIND_CUBIC  = 2'd1;

    localparam logic [0:0] OPC_PREPARE = 1'b0;

    localparam logic [63:0] ACCEL_SCALE = 64'd6000000000000;
    localparam logic [MUL_B_WIDTH-1:0] MICRO  = 32'd1000000;
    localparam logic [MUL_B_WIDTH-1:0] ACC_HI = 32'(ACCEL_SCALE >> ACC_SPLIT);
    localparam logic [MUL_B_WIDTH-1:0] ACC_LO = 32'(ACCEL_SCALE[ACC_SPLIT-1:0]);

    localparam logic [31:0] LIN_LINEAR = 32'h8000_0000;
    localparam logic [31:0] LIN_CUBIC  = 32'hC000_0000;
    localparam logic [32:0] CUB_CUBIC  = 33'h1_0000_0000;
    localparam logic [DUR_WIDTH-1:0] DUR_MAX = '1;
    localparam logic [NUM_WIDTH-1:0] SQ_MAX  = 76'h0_FFFF_FFFE_0000_0001;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } iter_rsp_t;

endpackage

[rtl/ctrg_iter_unit.sv]
// Shared restoring divide / square root unit, one result bit per cycle.
// Depends on ctrg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ctrg_iter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrg_pkg::iter_req_t           req,
    input  logic [ctrg_pkg::NUM_WIDTH-1:0] num,
    input  logic [ctrg_pkg::DEN_WIDTH-1:0] den,
    output ctrg_pkg::iter_rsp_t           rsp,
    output logic [ctrg_pkg::NUM_WIDTH-1:0] quo
);
    import ctrg_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    iter_op_t             op_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [NUM_WIDTH-1:0] shf_reg;
    logic [NUM_WIDTH-1:0] quo_reg;
    logic [REM_WIDTH-1:0] rem_reg;
    logic [DEN_WIDTH-1:0] den_reg;

    logic [REM_WIDTH:0]   lhs;
    logic [REM_WIDTH:0]   rhs;
    logic [REM_WIDTH+1:0] diff;
    logic                 ge;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            lhs = {rem_reg[REM_WIDTH-2:0], shf_reg[63:62]};
            rhs = {1'b0, quo_reg[31:0], 2'b01};
        end
        else
        begin
            lhs = {rem_reg, shf_reg[NUM_WIDTH-1]};
            rhs = (REM_WIDTH+1)'(den_reg);
        end
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = !diff[REM_WIDTH+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
            shf_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= req.op;
            cnt_reg  <= (req.op == OP_SQRT) ? CNT_WIDTH'(SQRT_STEPS - 1)
                                            : CNT_WIDTH'(DIV_STEPS - 1);
            shf_reg  <= num;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_WIDTH-1:0] : lhs[REM_WIDTH-1:0];
            quo_reg <= {quo_reg[NUM_WIDTH-2:0], ge};
            shf_reg <= (op_reg == OP_SQRT) ? (shf_reg << 2) : (shf_reg << 1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.rem_nz = (rem_reg != '0);
    assign quo        = quo_reg;

    `CTRG_ASSERT(a_start_when_idle, req.start |-> !busy_reg)
    `CTRG_ASSERT(a_done_after_work, done_reg |-> $past(busy_reg))

endmodule

[rtl/cubic_trim_reference_generator.sv]
// Top level of the trim reference generator: registers, sequencer, multiplier.
// Depends on ctrg_pkg, ctrg_iter_unit and assert_macros.svh.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------
//   input    | in_valid / in_stall      | opcode, sample_time
//   output   | out_valid / out_stall    | ref_out, running, status_code, duration_out
//   config   | cfg_we                   | cfg_index, cfg_data
//
// One transaction at a time; in_stall is high from acceptance until the result
// is loaded into the output register, which may still wait on out_stall.
// Prepares with an error or a set duration and samples unprepared or outside the trim
// skip the shared unit; a linear prepare runs a divide, a cubic one adds a divide and,
// if in range, a root; a sample inside the trim runs a divide, then the multiplier.
// Reset clears configuration, trim state and the output register.
`include "assert_macros.svh"
module cubic_trim_reference_generator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ctrg_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [ctrg_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   opcode,
    input  logic [ctrg_pkg::TIME_WIDTH-1:0]        sample_time,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [ctrg_pkg::REF_WIDTH-1:0]  ref_out,
    output logic                                   running,
    output logic [2:0]                             status_code,
    output logic [ctrg_pkg::DUR_WIDTH-1:0]         duration_out
);
    import ctrg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_P_MUL1, ST_P_DIV1, ST_P_WAIT1, ST_P_MUL2, ST_P_MUL3,
        ST_P_DIV2, ST_P_WAIT2, ST_P_SQRT, ST_P_WAITS, ST_P_FIN,
        ST_S_TIME, ST_S_DIV, ST_S_WAIT, ST_S_MUL1, ST_S_MUL2, ST_S_MUL3,
        ST_S_MUL4, ST_S_MUL5, ST_S_ADD, ST_OUT
    } state_t;

    state_t state_reg;

    logic signed [REF_WIDTH-1:0] init_reg, final_reg;
    logic [1:0]                  kind_reg;
    logic [DUR_WIDTH-1:0]        setdur_reg, rate_reg, accel_reg;
    logic [TIME_WIDTH-1:0]       delay_reg;

    logic                        prepared_reg;
    logic signed [REF_WIDTH-1:0] first_reg, last_reg, mid_reg;
    logic [TIME_WIDTH-1:0]       hdelay_reg;
    logic [32:0]                 ad_reg;
    logic                        dneg_reg;
    logic                        cubic_reg;
    logic [31:0]                 lin_reg;
    logic [32:0]                 cub_reg;
    logic [DUR_WIDTH-1:0]        tlen_reg;

    logic [NUM_WIDTH-1:0]        acc_reg;
    logic [DUR_WIDTH-1:0]        dur_reg;
    logic [2:0]                  status_reg;
    logic signed [REF_WIDTH-1:0] res_ref_reg;
    logic                        res_run_reg;
    logic [TIME_WIDTH-1:0]       time_reg;
    logic [30:0]                 u_reg;
    logic [30:0]                 minus_reg;
    logic                        tneg_reg;
    logic [PROD_WIDTH-1:0]       prod_reg;

    logic                        out_valid_reg, run_out_reg;
    logic signed [REF_WIDTH-1:0] ref_out_reg;
    logic [2:0]                  status_out_reg;
    logic [DUR_WIDTH-1:0]        dur_out_reg;

    iter_req_t             req;
    iter_rsp_t             rsp;
    logic [NUM_WIDTH-1:0]  iter_num, iter_quo;
    logic [DEN_WIDTH-1:0]  iter_den;

    logic [MUL_A_WIDTH-1:0] mul_a;
    logic [MUL_B_WIDTH-1:0] mul_b;

    logic signed [32:0]     delta;
    logic signed [32:0]     ref_sum;
    logic [32:0]            ad_c;
    logic [2:0]             prep_status;
    logic [MUL_A_WIDTH-1:0] kad;
    logic [TIME_WIDTH-1:0]  f;
    logic signed [33:0]     t2;
    logic [33:0]            at;
    logic [NUM_WIDTH-1:0]   q_ceil;
    logic [31:0]            s_ceil;
    logic [30:0]            prod_mid;
    logic [30:0]            p_val;
    logic [32:0]            adj;
    logic signed [33:0]     adj_s, sum_s;
    logic signed [REF_WIDTH-1:0] sat_ref;
    logic                   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        delta   = $signed({final_reg[REF_WIDTH-1], final_reg})
                - $signed({init_reg[REF_WIDTH-1], init_reg});
        ad_c    = delta[32] ? 33'(-delta) : 33'(delta);
        ref_sum = $signed({final_reg[REF_WIDTH-1], final_reg})
                + $signed({init_reg[REF_WIDTH-1], init_reg});
        if (kind_reg != KIND_LINEAR && kind_reg != KIND_CUBIC)
            prep_status = STS_BAD_TYPE;
        else if (setdur_reg == '0 && rate_reg == '0)
            prep_status = STS_NO_LIMITS;
        else if (setdur_reg == '0 && kind_reg == KIND_CUBIC && accel_reg == '0)
            prep_status = STS_BAD_ACCEL;
        else
            prep_status = STS_OK;

        kad      = {1'b0, ad_reg, 1'b0} + (cubic_reg ? MUL_A_WIDTH'(ad_reg) : '0);
        f        = time_reg - hdelay_reg;
        t2       = $signed({1'b0, f[31:0], 1'b0}) - $signed({2'b0, tlen_reg});
        at       = t2[33] ? 34'(-t2) : 34'(t2);
        q_ceil   = iter_quo + NUM_WIDTH'(rsp.rem_nz);
        s_ceil   = iter_quo[31:0] + 32'(rsp.rem_nz);
        prod_mid = prod_reg[61:31];
        p_val    = (prod_mid > minus_reg) ? (prod_mid - minus_reg) : '0;
        adj      = prod_reg[63:31];
        adj_s    = (tneg_reg ^ dneg_reg) ? -$signed({1'b0, adj}) : $signed({1'b0, adj});
        sum_s    = $signed({{2{mid_reg[REF_WIDTH-1]}}, mid_reg}) + adj_s;
        if (sum_s < -34'sh0_8000_0000)
            sat_ref = 32'sh8000_0000;
        else if (sum_s > 34'sh0_7FFF_FFFF)
            sat_ref = 32'sh7FFF_FFFF;
        else
            sat_ref = sum_s[31:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_P_MUL1:
            begin
                mul_a = kad;
                mul_b = MICRO;
            end
            ST_P_MUL2:
            begin
                mul_a = MUL_A_WIDTH'(ad_reg);
                mul_b = ACC_HI;
            end
            ST_P_MUL3:
            begin
                mul_a = MUL_A_WIDTH'(ad_reg);
                mul_b = ACC_LO;
            end
            ST_S_MUL1:
            begin
                mul_a = MUL_A_WIDTH'(u_reg);
                mul_b = MUL_B_WIDTH'(u_reg);
            end
            ST_S_MUL2:
            begin
                mul_a = MUL_A_WIDTH'(prod_mid);
                mul_b = MUL_B_WIDTH'(u_reg);
            end
            ST_S_MUL3:
            begin
                mul_a = MUL_A_WIDTH'(cub_reg);
                mul_b = MUL_B_WIDTH'(prod_mid);
            end
            ST_S_MUL4:
            begin
                mul_a = MUL_A_WIDTH'(lin_reg);
                mul_b = MUL_B_WIDTH'(u_reg);
            end
            ST_S_MUL5:
            begin
                mul_a = MUL_A_WIDTH'(ad_reg);
                mul_b = MUL_B_WIDTH'(p_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        req.start = (state_reg == ST_P_DIV1) || (state_reg == ST_P_DIV2)
                 || (state_reg == ST_P_SQRT) || (state_reg == ST_S_DIV);
        req.op    = (state_reg == ST_P_SQRT) ? OP_SQRT : OP_DIV;
        case (state_reg)
            ST_P_DIV1: iter_num = NUM_WIDTH'(prod_reg);
            ST_P_DIV2: iter_num = acc_reg + NUM_WIDTH'(prod_reg);
            default:   iter_num = acc_reg;
        endcase
        case (state_reg)
            ST_P_DIV1: iter_den = {rate_reg, 1'b0};
            ST_P_DIV2: iter_den = {1'b0, accel_reg};
            default:   iter_den = {1'b0, tlen_reg};
        endcase
    end

    ctrg_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .num   (iter_num),
        .den   (iter_den),
        .rsp   (rsp),
        .quo   (iter_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            init_reg       <= '0;
            final_reg      <= '0;
            kind_reg       <= '0;
            setdur_reg     <= '0;
            rate_reg       <= '0;
            accel_reg      <= '0;
            delay_reg      <= '0;
            prepared_reg   <= 1'b0;
            first_reg      <= '0;
            last_reg       <= '0;
            mid_reg        <= '0;
            hdelay_reg     <= '0;
            ad_reg         <= '0;
            dneg_reg       <= 1'b0;
            cubic_reg      <= 1'b0;
            lin_reg        <= '0;
            cub_reg        <= '0;
            tlen_reg       <= '0;
            acc_reg        <= '0;
            dur_reg        <= '0;
            status_reg     <= STS_OK;
            res_ref_reg    <= '0;
            res_run_reg    <= 1'b0;
            time_reg       <= '0;
            u_reg          <= '0;
            minus_reg      <= '0;
            tneg_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            ref_out_reg    <= '0;
            run_out_reg    <= 1'b0;
            status_out_reg <= STS_OK;
            dur_out_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INITIAL: init_reg   <= cfg_data[REF_WIDTH-1:0];
                    REG_FINAL:   final_reg  <= cfg_data[REF_WIDTH-1:0];
                    REG_KIND:    kind_reg   <= cfg_data[1:0];
                    REG_DUR:     setdur_reg <= cfg_data[DUR_WIDTH-1:0];
                    REG_RATE:    rate_reg   <= cfg_data[DUR_WIDTH-1:0];
                    REG_ACCEL:   accel_reg  <= cfg_data[DUR_WIDTH-1:0];
                    REG_DELAY:   delay_reg  <= cfg_data[TIME_WIDTH-1:0];
                    default:     ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_ref_reg <= '0;
                        res_run_reg <= 1'b0;
                        time_reg    <= sample_time;
                        if (opcode == OPC_PREPARE)
                        begin
                            first_reg  <= init_reg;
                            last_reg   <= final_reg;
                            hdelay_reg <= delay_reg;
                            ad_reg     <= ad_c;
                            dneg_reg   <= delta[32];
                            mid_reg    <= ref_sum[32:1];
                            cubic_reg  <= (kind_reg == KIND_CUBIC);
                            lin_reg    <= (kind_reg == KIND_CUBIC) ? LIN_CUBIC : LIN_LINEAR;
                            cub_reg    <= (kind_reg == KIND_CUBIC) ? CUB_CUBIC : '0;
                            status_reg <= prep_status;
                            dur_reg    <= (prep_status == STS_OK) ? setdur_reg : '0;
                            if (prep_status != STS_OK)
                            begin
                                prepared_reg <= 1'b0;
                                state_reg    <= ST_OUT;
                            end
                            else if (setdur_reg != '0)
                                state_reg <= ST_P_FIN;
                            else
                                state_reg <= ST_P_MUL1;
                        end
                        else if (!prepared_reg)
                        begin
                            status_reg <= STS_NOT_PREP;
                            dur_reg    <= '0;
                            state_reg  <= ST_OUT;
                        end
                        else
                        begin
                            status_reg <= STS_OK;
                            dur_reg    <= tlen_reg;
                            state_reg  <= ST_S_TIME;
                        end
                    end
                end
                ST_P_MUL1:  state_reg <= ST_P_DIV1;
                ST_P_DIV1:  state_reg <= ST_P_WAIT1;
                ST_P_WAIT1:
                begin
                    if (rsp.done)
                    begin
                        dur_reg   <= (q_ceil > NUM_WIDTH'(DUR_MAX)) ? DUR_MAX
                                                                   : q_ceil[31:0];
                        state_reg <= cubic_reg ? ST_P_MUL2 : ST_P_FIN;
                    end
                end
                ST_P_MUL2:  state_reg <= ST_P_MUL3;
                ST_P_MUL3:
                begin
                    acc_reg   <= NUM_WIDTH'(prod_reg) << ACC_SPLIT;
                    state_reg <= ST_P_DIV2;
                end
                ST_P_DIV2:  state_reg <= ST_P_WAIT2;
                ST_P_WAIT2:
                begin
                    if (rsp.done)
                    begin
                        if (q_ceil > SQ_MAX)
                        begin
                            dur_reg   <= DUR_MAX;
                            state_reg <= ST_P_FIN;
                        end
                        else
                        begin
                            acc_reg   <= q_ceil;
                            state_reg <= ST_P_SQRT;
                        end
                    end
                end
                ST_P_SQRT:  state_reg <= ST_P_WAITS;
                ST_P_WAITS:
                begin
                    if (rsp.done)
                    begin
                        if (s_ceil > dur_reg)
                            dur_reg <= s_ceil;
                        state_reg <= ST_P_FIN;
                    end
                end
                ST_P_FIN:
                begin
                    tlen_reg     <= dur_reg;
                    setdur_reg   <= dur_reg;
                    prepared_reg <= 1'b1;
                    state_reg    <= ST_OUT;
                end
                ST_S_TIME:
                begin
                    res_run_reg <= 1'b1;
                    if (time_reg <= hdelay_reg)
                    begin
                        res_ref_reg <= first_reg;
                        state_reg   <= ST_OUT;
                    end
                    else if (f <= TIME_WIDTH'(tlen_reg))
                    begin
                        tneg_reg  <= t2[33];
                        acc_reg   <= NUM_WIDTH'(at[31:0]) << 30;
                        state_reg <= ST_S_DIV;
                    end
                    else
                    begin
                        res_ref_reg <= last_reg;
                        res_run_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_S_DIV:   state_reg <= ST_S_WAIT;
                ST_S_WAIT:
                begin
                    if (rsp.done)
                    begin
                        u_reg     <= iter_quo[30:0];
                        state_reg <= ST_S_MUL1;
                    end
                end
                ST_S_MUL1:  state_reg <= ST_S_MUL2;
                ST_S_MUL2:  state_reg <= ST_S_MUL3;
                ST_S_MUL3:  state_reg <= ST_S_MUL4;
                ST_S_MUL4:
                begin
                    minus_reg <= prod_mid;
                    state_reg <= ST_S_MUL5;
                end
                ST_S_MUL5:  state_reg <= ST_S_ADD;
                ST_S_ADD:
                begin
                    res_ref_reg <= sat_ref;
                    state_reg   <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        ref_out_reg    <= res_ref_reg;
                        run_out_reg    <= res_run_reg;
                        status_out_reg <= status_reg;
                        dur_out_reg    <= dur_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign ref_out      = ref_out_reg;
    assign running      = run_out_reg;
    assign status_code  = status_out_reg;
    assign duration_out = dur_out_reg;

    `CTRG_ASSERT(a_accept_leaves_idle, (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
    `CTRG_ASSERT(a_done_while_waiting, rsp.done |-> (state_reg == ST_P_WAIT1 || state_reg == ST_P_WAIT2 || state_reg == ST_P_WAITS || state_reg == ST_S_WAIT))
    `CTRG_ASSERT_NEVER(a_root_in_range, (state_reg == ST_P_SQRT) && (acc_reg > SQ_MAX))

endmodule

[verif/tb_cubic_trim_reference_generator.sv]
// Testbench of the trim reference generator: a trim-profile predictor in a
// scoreboard class, directed and random prepare/sample traffic with random stalls.
// Depends on ctrg_pkg and the cubic_trim_reference_generator RTL.
module tb_cubic_trim_reference_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import ctrg_pkg::*;

    class trim_scoreboard;
        logic signed [63:0] init_r, final_r, held_first, held_last, mid;
        logic [1:0] kind;
        logic [63:0] set_dur, rate, accel, delay, held_delay;
        logic [63:0] lin_c, cub_c, tlen, half;
        bit prepared;
        logic [31:0] exp_ref[$];
        logic exp_run[$];
        logic [2:0] exp_sts[$];
        logic [31:0] exp_dur[$];
        int mismatches;
        int checked;

        function void write_reg(logic [2:0] idx, logic [47:0] v);
            case (idx)
                REG_INITIAL: init_r = $signed(v[31:0]);
                REG_FINAL: final_r = $signed(v[31:0]);
                REG_KIND: kind = v[1:0];
                REG_DUR: set_dur = {32'd0, v[31:0]};
                REG_RATE: rate = {32'd0, v[31:0]};
                REG_ACCEL: accel = {32'd0, v[31:0]};
                REG_DELAY: delay = {16'd0, v};
                default: ;
            endcase
        endfunction

        function logic [63:0] ceil_sqrt(logic [127:0] x);
            logic [127:0] lo, hi, m;
            lo = 0;
            hi = 128'h1_0000_0000_0000_0000;
            while (lo < hi)
            begin
                m = (lo + hi) >> 1;
                if (m * m >= x) hi = m;
                else lo = m + 1;
            end
            return lo[63:0];
        endfunction

        function logic [2:0] do_prepare(output logic [31:0] dur_o);
            logic signed [63:0] dl, sum;
            logic [127:0] ad, q, d2;
            logic [63:0] dur;
            dur_o = 0;
            dl = final_r - init_r;
            ad = dl < 0 ? -dl : dl;
            if (kind != KIND_LINEAR && kind != KIND_CUBIC) return STS_BAD_TYPE;
            dur = set_dur;
            if (dur == 0)
            begin
                if (rate == 0) return STS_NO_LIMITS;
                if (kind == KIND_CUBIC && accel == 0) return STS_BAD_ACCEL;
                q = ((kind == KIND_CUBIC ? 3 : 2) * ad * 1000000 + 2 * rate - 1)
                    / (2 * rate);
                dur = q > 128'hFFFF_FFFF ? 64'hFFFF_FFFF : q[63:0];
                if (kind == KIND_CUBIC)
                begin
                    q = (6 * ad * 128'd1000000000000 + accel - 1) / accel;
                    if (q >= 128'h1_0000_0000_0000_0000) d2 = 128'hFFFF_FFFF;
                    else d2 = ceil_sqrt(q);
                    if (d2 > 128'hFFFF_FFFF) d2 = 128'hFFFF_FFFF;
                    if (d2 > dur) dur = d2[63:0];
                end
                set_dur = dur;
            end
            tlen = dur;
            half = dur >> 1;
            lin_c = kind == KIND_CUBIC ? 64'hC000_0000 : 64'h8000_0000;
            cub_c = kind == KIND_CUBIC ? 64'h1_0000_0000 : 0;
            held_first = init_r;
            held_last = final_r;
            held_delay = delay;
            sum = init_r + final_r;
            mid = sum >>> 1;
            prepared = 1;
            dur_o = dur[31:0];
            return STS_OK;
        endfunction

        function logic signed [63:0] trim_value(logic [63:0] f);
            logic signed [63:0] t2, dl, adj;
            logic [127:0] ad, at, u, u2, u3, plus, minus, p;
            t2 = 2 * ($signed(f) - $signed(half)) - $signed({63'd0, tlen[0]});
            dl = held_last - held_first;
            ad = dl < 0 ? -dl : dl;
            at = t2 < 0 ? -t2 : t2;
            u = (at << 30) / tlen;
            u2 = (u * u) >> 31;
            u3 = (u2 * u) >> 31;
            plus = (lin_c * u) >> 31;
            minus = (cub_c * u3) >> 31;
            p = plus > minus ? plus - minus : 0;
            adj = (ad * p) >> 31;
            if ((t2 < 0) != (dl < 0)) adj = -adj;
            return mid + adj;
        endfunction

        function void note_input(logic op, logic [47:0] t);
            logic signed [63:0] r;
            logic run;
            logic [2:0] s;
            logic [31:0] d;
            logic [63:0] tt;
            r = 0;
            run = 0;
            d = 0;
            tt = {16'd0, t};
            if (op == OPC_PREPARE)
            begin
                s = do_prepare(d);
                if (s != STS_OK) prepared = 0;
            end
            else if (!prepared)
                s = STS_NOT_PREP;
            else
            begin
                s = STS_OK;
                d = tlen[31:0];
                run = 1;
                if (tt <= held_delay) r = held_first;
                else if (tt - held_delay <= tlen) r = trim_value(tt - held_delay);
                else
                begin
                    r = held_last;
                    run = 0;
                end
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                if (r > 64'sd2147483647) r = 64'sd2147483647;
            end
            exp_ref.push_back(r[31:0]);
            exp_run.push_back(run);
            exp_sts.push_back(s);
            exp_dur.push_back(d);
        endfunction

        function void check_result(logic [31:0] r, logic run, logic [2:0] s,
                                   logic [31:0] d);
            logic [31:0] er, ed;
            logic erun;
            logic [2:0] es;
            checked++;
            if (exp_ref.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result ref=%h", r);
                return;
            end
            er = exp_ref.pop_front();
            erun = exp_run.pop_front();
            es = exp_sts.pop_front();
            ed = exp_dur.pop_front();
            if (er !== r || erun !== run || es !== s || ed !== d)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp ref=%h run=%b sts=%0d dur=%0d,",
                              " got ref=%h run=%b sts=%0d dur=%0d"},
                             er, erun, es, ed, r, run, s, d);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = 0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic opcode = 0;
    logic [TIME_WIDTH-1:0] sample_time = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [REF_WIDTH-1:0] ref_out;
    logic running;
    logic [2:0] status_code;
    logic [DUR_WIDTH-1:0] duration_out;

    trim_scoreboard trims = new();
    bit calm = 0;
    int prepares = 0;
    int samples = 0;

    cubic_trim_reference_generator dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            trims.check_result(ref_out, running, status_code, duration_out);
    end

    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [47:0] v);
        in_valid <= 0;
        while (trims.exp_ref.size() != 0) @(negedge clk);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        trims.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (trims.exp_ref.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send(logic op, logic [47:0] t);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1;
        opcode <= op;
        sample_time <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        trims.note_input(op, t);
        if (op == OPC_PREPARE) prepares++;
        else samples++;
        @(negedge clk);
    endtask

    function automatic logic [47:0] pick_time(logic [47:0] dly, logic [31:0] d);
        logic [63:0] t;
        case ($urandom_range(0, 7))
            0: t = {$urandom, $urandom};
            1: t = dly;
            2: t = dly + d;
            3: t = dly + d + 1;
            4: t = dly + 1;
            default: t = dly + {$urandom, $urandom} % ({32'd0, d} + 1);
        endcase
        return t[47:0];
    endfunction

    task automatic random_setup(int mode);
        logic [31:0] a, b;
        a = $urandom;
        b = $urandom;
        if (mode == 0) b = a + ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
        write_cfg(REG_INITIAL, {16'd0, a});
        write_cfg(REG_FINAL, {16'd0, b});
        write_cfg(REG_KIND, $urandom_range(0, 9) == 0 ? $urandom_range(2, 3)
                                                       : $urandom_range(0, 1));
        write_cfg(REG_DUR, $urandom_range(0, 1) ? 0 :
                  ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 5000)));
        write_cfg(REG_RATE, $urandom_range(0, 12) == 0 ? 0 :
                  ($urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h00FF_FFFF)));
        write_cfg(REG_ACCEL, $urandom_range(0, 12) == 0 ? 0 : $urandom);
        write_cfg(REG_DELAY, {$urandom, $urandom});
    endtask

    initial
    begin
        int k;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        send(1, 48'd5);
        send(OPC_PREPARE, 0);
        write_cfg(REG_KIND, 2);
        send(OPC_PREPARE, 0);
        write_cfg(REG_KIND, 3);
        send(OPC_PREPARE, 0);
        send(1, 48'd5);
        write_cfg(REG_KIND, KIND_CUBIC);
        write_cfg(REG_FINAL, 48'h0000_7FFF_FFFF);
        write_cfg(REG_INITIAL, 48'h0000_8000_0000);
        write_cfg(REG_RATE, 1);
        send(OPC_PREPARE, 0);
        drain();
        write_cfg(REG_ACCEL, 48'hFFFF_FFFF);
        send(OPC_PREPARE, 0);
        drain();
        write_cfg(REG_RATE, 32'hFFFF_FFFF);
        write_cfg(REG_ACCEL, 1);
        send(OPC_PREPARE, 0);
        drain();
        write_cfg(REG_DUR, 1000);
        write_cfg(REG_DELAY, 48'hFFFF_FFFF_F000);
        send(OPC_PREPARE, 0);
        send(1, 0);
        send(1, 48'hFFFF_FFFF_FFFF);
        send(1, 48'hFFFF_FFFF_F001);
        send(1, 48'hFFFF_FFFF_F1F4);
        send(1, 48'hFFFF_FFFF_F3E8);
        write_cfg(REG_KIND, KIND_LINEAR);
        write_cfg(REG_DELAY, 100);
        send(1, 48'd600);
        send(OPC_PREPARE, 0);
        send(1, 48'd101);
        send(1, 48'd600);
        send(1, 48'd1100);
        write_cfg(7, 48'h1234);
        for (k = 0; k < 185; k++)
        begin
            drain();
            if (k == 165) calm = 1;
            random_setup(k % 3);
            send(OPC_PREPARE, 0);
            drain();
            repeat ($urandom_range(3, 9))
                send($urandom_range(0, 15) != 0,
                     pick_time(trims.held_delay, trims.tlen[31:0]));
        end
        drain();
        repeat (20) @(negedge clk);
        $display("covered %0d prepares and %0d samples, %0d results checked",
                 prepares, samples, trims.checked);
        if (trims.mismatches == 0 && trims.exp_ref.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
